// ===== design/hhfl_pkg.sv =====
// Shared types, constants and prefix tables for the HTTP header field locator.
package hhfl_pkg;

    localparam int OFFSET_W             = 17;
    localparam int POS_W                = 5;
    localparam int NUM_PREFIX           = 6;
    localparam int MAX_BUFFER_BYTES_DEF = 65536;

    localparam logic [7:0]       CHAR_CR = 8'h0d;
    localparam logic [7:0]       CHAR_LF = 8'h0a;
    localparam logic [POS_W-1:0] POS_MAX = 5'd31;
    localparam logic [OFFSET_W-1:0] BODY_SKIP = 17'd2;

    typedef enum logic [2:0] {
        KIND_GET            = 3'd0,
        KIND_POST           = 3'd1,
        KIND_HOST           = 3'd2,
        KIND_UPGRADE        = 3'd3,
        KIND_CONNECTION     = 3'd4,
        KIND_CONTENT_LENGTH = 3'd5,
        KIND_BODY_START     = 3'd6,
        KIND_BUFFER_END     = 3'd7
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [OFFSET_W-1:0] offset;
        logic                final_res;
    } result_t;

    // Results produced by one byte: zero, one or two, in delivery order.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    // Prefix text, right-aligned: character p of a prefix of length L sits
    // at bits [8*(L-1-p) +: 8].
    localparam logic [127:0] PFX_TEXT [NUM_PREFIX] = '{
        "GET ", "POST ", "Host: ", "Upgrade: ", "Connection: ", "Content-Length: "
    };

    localparam logic [POS_W-1:0] PFX_LEN [NUM_PREFIX] = '{
        5'd4, 5'd5, 5'd6, 5'd9, 5'd12, 5'd16
    };

    function automatic logic [7:0] pfx_byte(input int unsigned idx,
                                            input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] rev;
        logic [3:0]       sel;
        rev = PFX_LEN[idx] - 5'd1 - pos;
        sel = rev[3:0];
        return PFX_TEXT[idx][{sel, 3'b000} +: 8];
    endfunction

endpackage

// ===== design/hhfl_in_if.sv =====
// Byte input channel of the HTTP header field locator.
interface hhfl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

// ===== design/hhfl_out_if.sv =====
// Result output channel of the HTTP header field locator.
interface hhfl_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [16:0] offset;
    logic        final_res;

    modport source (output valid, output kind, output offset, output final_res, input ready);
    modport sink   (input valid, input kind, input offset, input final_res, output ready);
endinterface

// ===== design/hhfl_parser.sv =====
// Per-byte line tracker and prefix matcher; emits up to two results per byte.
module hhfl_parser #(
    parameter int MAX_BUFFER_BYTES = hhfl_pkg::MAX_BUFFER_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     data_byte,
    input  logic           last,
    output hhfl_pkg::push_t push
);

    localparam logic [hhfl_pkg::OFFSET_W-1:0] MAX_COUNT =
        hhfl_pkg::OFFSET_W'(MAX_BUFFER_BYTES);

    logic [hhfl_pkg::OFFSET_W-1:0]   byte_count_reg, byte_count_next;
    logic [hhfl_pkg::OFFSET_W-1:0]   line_start_reg, line_start_next;
    logic [hhfl_pkg::POS_W-1:0]      line_position_reg, line_position_next;
    logic                            previous_was_cr_reg, previous_was_cr_next;
    logic                            first_byte_cr_reg, first_byte_cr_next;
    logic [hhfl_pkg::NUM_PREFIX-1:0] match_reg, match_next;
    logic                            headers_done_reg, headers_done_next;

    logic                            counting;
    logic                            line_end;
    logic                            line_hit;
    hhfl_pkg::result_t               line_res;
    hhfl_pkg::result_t               end_res;
    logic [hhfl_pkg::OFFSET_W-1:0]   count_inc;

    always_comb
    begin
        byte_count_next      = byte_count_reg;
        line_start_next      = line_start_reg;
        line_position_next   = line_position_reg;
        previous_was_cr_next = previous_was_cr_reg;
        first_byte_cr_next   = first_byte_cr_reg;
        match_next           = match_reg;
        headers_done_next    = headers_done_reg;

        counting  = byte_count_reg < MAX_COUNT;
        count_inc = byte_count_reg + 17'd1;
        line_end  = counting && !headers_done_reg &&
                    (data_byte == hhfl_pkg::CHAR_LF) && previous_was_cr_reg;

        // Pick the line result: blank line marks the body, else first matching prefix.
        line_hit        = 1'b0;
        line_res.kind   = hhfl_pkg::KIND_BODY_START;
        line_res.offset = line_start_reg + hhfl_pkg::BODY_SKIP;
        line_res.final_res = 1'b0;
        if (first_byte_cr_reg)
        begin
            line_hit = 1'b1;
        end
        else
        begin
            for (int unsigned i = 0; i < hhfl_pkg::NUM_PREFIX; i++)
            begin
                if (match_reg[i] && !line_hit)
                begin
                    line_hit        = 1'b1;
                    line_res.kind   = hhfl_pkg::kind_t'(i);
                    line_res.offset = line_start_reg +
                                      hhfl_pkg::OFFSET_W'(hhfl_pkg::PFX_LEN[i]);
                end
            end
        end

        if (accept && counting)
        begin
            byte_count_next = count_inc;
            if (!headers_done_reg)
            begin
                if (line_end)
                begin
                    if (first_byte_cr_reg)
                    begin
                        headers_done_next = 1'b1;
                    end
                    line_start_next      = count_inc;
                    line_position_next   = '0;
                    previous_was_cr_next = 1'b0;
                    first_byte_cr_next   = 1'b0;
                    match_next           = '1;
                end
                else
                begin
                    if (line_position_reg == '0 && data_byte == hhfl_pkg::CHAR_CR)
                    begin
                        first_byte_cr_next = 1'b1;
                    end
                    for (int unsigned i = 0; i < hhfl_pkg::NUM_PREFIX; i++)
                    begin
                        if (line_position_reg < hhfl_pkg::PFX_LEN[i] &&
                            data_byte != hhfl_pkg::pfx_byte(i, line_position_reg))
                        begin
                            match_next[i] = 1'b0;
                        end
                    end
                    if (line_position_reg < hhfl_pkg::POS_MAX)
                    begin
                        line_position_next = line_position_reg + 5'd1;
                    end
                    previous_was_cr_next = (data_byte == hhfl_pkg::CHAR_CR);
                end
            end
        end

        end_res.kind      = hhfl_pkg::KIND_BUFFER_END;
        end_res.offset    = byte_count_next;
        end_res.final_res = 1'b1;

        // Order results: line result first, buffer end behind it.
        push.count  = 2'd0;
        push.first  = end_res;
        push.second = end_res;
        if (accept)
        begin
            if (line_end && line_hit)
            begin
                push.first = line_res;
                push.count = last ? 2'd2 : 2'd1;
            end
            else if (last)
            begin
                push.count = 2'd1;
            end
        end

        // Final byte returns everything to the reset state.
        if (accept && last)
        begin
            byte_count_next      = '0;
            line_start_next      = '0;
            line_position_next   = '0;
            previous_was_cr_next = 1'b0;
            first_byte_cr_next   = 1'b0;
            match_next           = '1;
            headers_done_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg      <= '0;
            line_start_reg      <= '0;
            line_position_reg   <= '0;
            previous_was_cr_reg <= 1'b0;
            first_byte_cr_reg   <= 1'b0;
            match_reg           <= '1;
            headers_done_reg    <= 1'b0;
        end
        else
        begin
            byte_count_reg      <= byte_count_next;
            line_start_reg      <= line_start_next;
            line_position_reg   <= line_position_next;
            previous_was_cr_reg <= previous_was_cr_next;
            first_byte_cr_reg   <= first_byte_cr_next;
            match_reg           <= match_next;
            headers_done_reg    <= headers_done_next;
        end
    end

endmodule

// ===== design/hhfl_result_fifo.sv =====
// Four-entry result queue that takes up to two results per cycle.
module hhfl_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  hhfl_pkg::push_t   push,
    output logic              space,
    output logic              out_valid,
    input  logic              out_ready,
    output hhfl_pkg::result_t out_data
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    hhfl_pkg::result_t mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PTR_W-1:0]  wr_ptr_1;
    logic              pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // Keep room for the worst case of two results from the next byte.
    assign space     = (count_reg <= CNT_W'(DEPTH - 2));
    assign wr_ptr_1  = wr_ptr_reg + PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/http_header_field_locator.sv =====
// Top level of the HTTP header field locator: byte parser and result queue.
//
//  channel | role   | payload                          | transaction
//  --------+--------+----------------------------------+------------------------------
//  in_ch   | sink   | data_byte[7:0], last             | one request byte
//  out_ch  | source | kind[2:0], offset[16:0], final_res | one located field or marker
//
// One byte per cycle: the parser updates its line state in the same cycle a byte
// is taken, and its results land in a four-entry queue read from registers.
// A byte can yield two results (a line result and the buffer end); the input
// stalls only while the queue holds more than two results, so the rate is one
// byte per cycle whenever out_ch drains at least as fast as results appear.
// Reset clears the counters, line state and queue; no clearing pass is needed.
module http_header_field_locator #(
    parameter int MAX_BUFFER_BYTES = hhfl_pkg::MAX_BUFFER_BYTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    hhfl_in_if.sink   in_ch,
    hhfl_out_if.source out_ch
);

    hhfl_pkg::push_t   push;
    hhfl_pkg::result_t head;
    logic              space;
    logic              accept;

    // Take a byte only when the queue can absorb both possible results.
    assign in_ch.ready = space;
    assign accept      = in_ch.valid && space;

    hhfl_parser #(
        .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (in_ch.data_byte),
        .last      (in_ch.last),
        .push      (push)
    );

    // Hold results here until the consumer takes them.
    hhfl_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space     (space),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (head)
    );

    assign out_ch.kind      = head.kind;
    assign out_ch.offset    = head.offset;
    assign out_ch.final_res = head.final_res;

endmodule
